/* rtl/assert_macros.svh */
// Assertion macros shared by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/ple_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the list engine.
package ple_pkg;

  localparam int DEPTH      = 64;  // must be a power of two (circular addressing)
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OP_W       = 4;
  localparam int ST_W       = 2;
  localparam int POS_W      = 7;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd3;
  localparam logic [OP_W-1:0] OP_PEEK_ENDS  = 4'd4;
  localparam logic [OP_W-1:0] OP_READ       = 4'd5;
  localparam logic [OP_W-1:0] OP_WRITE      = 4'd6;
  localparam logic [OP_W-1:0] OP_INSERT     = 4'd7;
  localparam logic [OP_W-1:0] OP_DELETE     = 4'd8;
  localparam logic [OP_W-1:0] OP_SEARCH     = 4'd9;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd3;

  // Logical (front-relative) address sources for single accesses.
  typedef enum logic [2:0] {
    A_FIRST,
    A_LAST,
    A_POS,
    A_END,
    A_BEFORE
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      wr_en;
    addr_sel_t wr_sel;
    logic      cap_dv;
    logic      cap_lv;
    logic      walk_start;
    logic      walk_step;
    logic      walk_use;
    logic      commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ST_W-1:0] err;
    logic            cnt_zero;
    logic            walk_last;
  } dp_stat_t;

endpackage

/* rtl/positional_list_engine_unit.sv */
// Top level of the positional list engine: controller plus datapath.
// Bounded list of up to 64 signed 32-bit words kept in a circular single-port-write
// memory with a registered read, so each transaction runs one at a time. Push
// front/back, write, failed commands, unused codes and a search of an empty list go
// from dispatch straight to commit; pop and read first capture one registered read,
// peek_ends two (first, then last element). The result is registered at commit.
// Insert, delete and search walk the affected elements through the memory one
// per cycle, then use the last read; insert ends with a write of the new value. That
// walk through the memory sets the rate. A new transaction is accepted while the
// previous result still waits at the output register; it then holds at its commit
// step until that result is taken.
module positional_list_engine_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ple_pkg::OP_W-1:0]              in_opcode,
  input  logic signed [ple_pkg::DATA_WIDTH-1:0] in_value,
  input  logic [ple_pkg::POS_W-1:0]             in_position,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ple_pkg::ST_W-1:0]              out_status,
  output logic signed [ple_pkg::DATA_WIDTH-1:0] out_data_value,
  output logic signed [ple_pkg::DATA_WIDTH-1:0] out_last_value,
  output logic [ple_pkg::POS_W-1:0]             out_found_position,
  output logic                                  out_found,
  output logic [ple_pkg::POS_W-1:0]             out_length
);
  import ple_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ple_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_opcode),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_status         (out_status),
    .out_data_value     (out_data_value),
    .out_last_value     (out_last_value),
    .out_found_position (out_found_position),
    .out_found          (out_found),
    .out_length         (out_length)
  );

endmodule

/* rtl/ple_dpath.sv */
// List engine datapath: circular element memory, pointers, walk index and result registers.
`include "assert_macros.svh"

module ple_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ple_pkg::ctl_cmd_t                  cmd,
  output ple_pkg::dp_stat_t                  stat,
  input  logic [ple_pkg::OP_W-1:0]           in_opcode,
  input  logic signed [ple_pkg::DATA_WIDTH-1:0] in_value,
  input  logic [ple_pkg::POS_W-1:0]          in_position,
  output logic [ple_pkg::ST_W-1:0]           out_status,
  output logic signed [ple_pkg::DATA_WIDTH-1:0] out_data_value,
  output logic signed [ple_pkg::DATA_WIDTH-1:0] out_last_value,
  output logic [ple_pkg::POS_W-1:0]          out_found_position,
  output logic                               out_found,
  output logic [ple_pkg::POS_W-1:0]          out_length
);
  import ple_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  logic [OP_W-1:0]       op_r;
  logic [DATA_WIDTH-1:0] sval_r;
  logic [POS_W-1:0]      pos_r;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      idx_r, prev_r;
  logic [DATA_WIDTH-1:0] dv_acc_r, lv_acc_r;
  logic [CNT_W-1:0]      fpos_acc_r;
  logic                  fnd_acc_r;

  logic [ST_W-1:0]       out_status_r;
  logic [DATA_WIDTH-1:0] out_dv_r, out_lv_r;
  logic [CNT_W-1:0]      out_fpos_r, out_len_r;
  logic                  out_fnd_r;

  logic [IDX_W-1:0] pos_idx, last_idx, rd_log, wr_log, walk_wr_log;
  logic [IDX_W-1:0] rd_phys, wr_phys;
  logic [DATA_WIDTH-1:0] wdata;
  logic [ST_W-1:0] err;
  logic pos_ok, full, empty, walk_up, walk_wr, mem_we, mem_rd, ok, sval_op;

  assign pos_idx  = IDX_W'(pos_r - POS_W'(1));
  assign last_idx = IDX_W'(count_r - CNT_W'(1));
  assign pos_ok   = (pos_r != '0) && (CNT_W'(pos_r) <= count_r);
  assign full     = (count_r == DEPTH_CNT);
  assign empty    = (count_r == '0);
  assign walk_up  = (op_r != OP_INSERT);

  always_comb begin
    case (op_r)
      OP_PUSH_FRONT, OP_PUSH_BACK:          err = full ? ST_FULL : ST_OK;
      OP_POP_FRONT, OP_POP_BACK, OP_PEEK_ENDS: err = empty ? ST_EMPTY : ST_OK;
      OP_READ, OP_WRITE, OP_DELETE:         err = pos_ok ? ST_OK : ST_BADPOS;
      OP_INSERT:  err = !pos_ok ? ST_BADPOS : (full ? ST_FULL : ST_OK);
      default:    err = ST_OK;
    endcase
  end

  assign stat.op        = op_r;
  assign stat.err       = err;
  assign stat.cnt_zero  = empty;
  assign stat.walk_last = walk_up ? (idx_r == last_idx) : (idx_r == pos_idx);

  always_comb begin
    case (cmd.rd_sel)
      A_FIRST:  rd_log = '0;
      A_LAST:   rd_log = last_idx;
      A_POS:    rd_log = pos_idx;
      A_END:    rd_log = IDX_W'(count_r);
      A_BEFORE: rd_log = '1;
      default:  rd_log = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      A_FIRST:  wr_log = '0;
      A_LAST:   wr_log = last_idx;
      A_POS:    wr_log = pos_idx;
      A_END:    wr_log = IDX_W'(count_r);
      A_BEFORE: wr_log = '1;
      default:  wr_log = '0;
    endcase
  end

  // Shift moves: insert copies each element one place back, delete one place forward.
  // For delete the first element read is the one removed, so it is not written.
  assign walk_wr = cmd.walk_use &&
                   ((op_r == OP_INSERT) || ((op_r == OP_DELETE) && (prev_r != pos_idx)));
  assign walk_wr_log = (op_r == OP_INSERT) ? prev_r + IDX_W'(1) : prev_r - IDX_W'(1);

  assign wr_phys = head_r + (walk_wr ? walk_wr_log : wr_log);
  assign rd_phys = head_r + (cmd.walk_step ? idx_r : rd_log);
  assign wdata   = walk_wr ? rdata_r : sval_r;
  assign mem_we  = cmd.wr_en || walk_wr;
  assign mem_rd  = cmd.rd_en || cmd.walk_step;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_phys] <= wdata;
    end
    if (mem_rd) begin
      rdata_r <= mem[rd_phys];
    end
  end

  assign ok      = (err == ST_OK);
  assign sval_op = (op_r == OP_PUSH_FRONT) || (op_r == OP_PUSH_BACK) ||
                   (op_r == OP_WRITE) || (op_r == OP_INSERT);

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (ok) begin
      case (op_r)
        OP_PUSH_FRONT: begin
          head_nxt  = head_r - IDX_W'(1);
          count_nxt = count_r + CNT_W'(1);
        end
        OP_PUSH_BACK, OP_INSERT: count_nxt = count_r + CNT_W'(1);
        OP_POP_FRONT: begin
          head_nxt  = head_r + IDX_W'(1);
          count_nxt = count_r - CNT_W'(1);
        end
        OP_POP_BACK, OP_DELETE: count_nxt = count_r - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.commit) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_opcode;
      sval_r     <= in_value;
      pos_r      <= in_position;
      dv_acc_r   <= '0;
      lv_acc_r   <= '0;
      fpos_acc_r <= '0;
      fnd_acc_r  <= 1'b0;
    end
    if (cmd.walk_start) begin
      case (op_r)
        OP_INSERT: idx_r <= last_idx;
        OP_DELETE: idx_r <= pos_idx;
        default:   idx_r <= '0;
      endcase
    end
    if (cmd.walk_step) begin
      idx_r  <= walk_up ? idx_r + IDX_W'(1) : idx_r - IDX_W'(1);
      prev_r <= idx_r;
    end
    if (cmd.cap_dv) begin
      dv_acc_r <= rdata_r;
    end
    if (cmd.cap_lv) begin
      lv_acc_r <= rdata_r;
    end
    if (cmd.walk_use) begin
      if ((op_r == OP_DELETE) && (prev_r == pos_idx)) begin
        dv_acc_r <= rdata_r;
      end
      // ascending walk, so a later match overwrites an earlier one
      if ((op_r == OP_SEARCH) && (rdata_r == sval_r)) begin
        fpos_acc_r <= CNT_W'(prev_r) + CNT_W'(1);
        fnd_acc_r  <= 1'b1;
      end
    end
    if (cmd.commit) begin
      out_status_r <= err;
      out_dv_r     <= (ok && sval_op) ? sval_r : dv_acc_r;
      out_lv_r     <= lv_acc_r;
      out_fpos_r   <= fpos_acc_r;
      out_fnd_r    <= fnd_acc_r;
      out_len_r    <= count_nxt;
    end
  end

  assign out_status         = out_status_r;
  assign out_data_value     = out_dv_r;
  assign out_last_value     = out_lv_r;
  assign out_found_position = POS_W'(out_fpos_r);
  assign out_found          = out_fnd_r;
  assign out_length         = POS_W'(out_len_r);

  `ASSERT_NEVER(a_count_range, count_r > DEPTH_CNT, "element count above depth")
  `ASSERT_NEVER(a_write_clash, cmd.wr_en && walk_wr, "two writes to element memory in one cycle")

endmodule

/* rtl/ple_ctrl.sv */
// List engine controller: sequences each transaction and owns both handshakes.
`include "assert_macros.svh"

module ple_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  ple_pkg::dp_stat_t    stat,
  output ple_pkg::ctl_cmd_t    cmd
);
  import ple_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RDATA,
    S_RLAST,
    S_WALK,
    S_DRAIN,
    S_INS_WR,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   pend_r, pend_nxt;  // a walk read is in flight

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_COMMIT;
        if (stat.err == ST_OK) begin
          case (stat.op)
            OP_PUSH_FRONT: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = A_BEFORE;
            end
            OP_PUSH_BACK: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = A_END;
            end
            OP_WRITE: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = A_POS;
            end
            OP_POP_FRONT, OP_PEEK_ENDS: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = A_FIRST;
              state_nxt  = S_RDATA;
            end
            OP_POP_BACK: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = A_LAST;
              state_nxt  = S_RDATA;
            end
            OP_READ: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = A_POS;
              state_nxt  = S_RDATA;
            end
            OP_INSERT, OP_DELETE: begin
              cmd.walk_start = 1'b1;
              state_nxt      = S_WALK;
            end
            OP_SEARCH: begin
              if (!stat.cnt_zero) begin
                cmd.walk_start = 1'b1;
                state_nxt      = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_RDATA: begin
        cmd.cap_dv = 1'b1;
        if (stat.op == OP_PEEK_ENDS) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = A_LAST;
          state_nxt  = S_RLAST;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_RLAST: begin
        cmd.cap_lv = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.walk_use  = pend_r;
        pend_nxt      = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.walk_use = 1'b1;
        pend_nxt     = 1'b0;
        state_nxt    = (stat.op == OP_INSERT) ? S_INS_WR : S_COMMIT;
      end
      S_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = A_POS;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  `ASSERT_NEVER(a_no_overwrite, cmd.commit && out_valid_r && out_stall, "result overwritten while held")
  `ASSERT_CLK(a_pend_in_walk, pend_r |-> (state_r == S_WALK || state_r == S_DRAIN), "walk read pending outside walk")

endmodule

/* tb/positional_list_engine_unit_test.sv */
// Self-checking testbench for the positional list engine: shadow list, stimulus and checks.
`timescale 1ns / 100ps

module positional_list_engine_unit_test;
  import ple_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int RANDOM_COMMANDS = 1450;
  localparam int PHASE_LEN = 200;
  localparam int HOLD_AFTER = 200;   // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 80;  // a little over the longest walk
  localparam logic signed [DW-1:0] MIN_WORD = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] MAX_WORD = {1'b0, {(DW-1){1'b1}}};
  localparam logic [OP_W-1:0] OP_LAST_CODE = {OP_W{1'b1}};
  localparam logic [POS_W-1:0] POS_TOP = {POS_W{1'b1}};

  typedef enum int {GROW, MIXED, SHRINK} list_trend_t;

  typedef struct packed {
    logic [ST_W-1:0]        status;
    logic signed [DW-1:0]   data_value;
    logic signed [DW-1:0]   last_value;
    logic [POS_W-1:0]       found_position;
    logic                   found;
    logic [POS_W-1:0]       length;
  } list_reply_t;

  // Shadow copy of the list; computes the reply each accepted command owes.
  class list_shadow;
    logic signed [DW-1:0] elems[$];
    list_reply_t owed_replies[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void apply_command(logic [OP_W-1:0] op, logic signed [DW-1:0] val,
                                logic [POS_W-1:0] pos);
      list_reply_t r;
      int p;
      bit pos_ok;
      r = '0;
      p = int'(pos);
      pos_ok = (p >= 1) && (p <= elems.size());
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (elems.size() >= DEPTH) r.status = ST_FULL;
          else begin
            if (op == OP_PUSH_FRONT) elems.push_front(val);
            else elems.push_back(val);
            r.data_value = val;
          end
        end
        OP_POP_FRONT: begin
          if (elems.size() == 0) r.status = ST_EMPTY;
          else r.data_value = elems.pop_front();
        end
        OP_POP_BACK: begin
          if (elems.size() == 0) r.status = ST_EMPTY;
          else r.data_value = elems.pop_back();
        end
        OP_PEEK_ENDS: begin
          if (elems.size() == 0) r.status = ST_EMPTY;
          else begin
            r.data_value = elems[0];
            r.last_value = elems[elems.size()-1];
          end
        end
        OP_READ: begin
          if (!pos_ok) r.status = ST_BADPOS;
          else r.data_value = elems[p-1];
        end
        OP_WRITE: begin
          if (!pos_ok) r.status = ST_BADPOS;
          else begin
            elems[p-1] = val;
            r.data_value = val;
          end
        end
        OP_INSERT: begin
          if (!pos_ok) r.status = ST_BADPOS;
          else if (elems.size() >= DEPTH) r.status = ST_FULL;
          else begin
            elems.insert(p-1, val);
            r.data_value = val;
          end
        end
        OP_DELETE: begin
          if (!pos_ok) r.status = ST_BADPOS;
          else begin
            r.data_value = elems[p-1];
            elems.delete(p-1);
          end
        end
        OP_SEARCH: begin
          // last match wins
          for (int i = 0; i < elems.size(); i++) begin
            if (elems[i] == val) begin
              r.found_position = POS_W'(i + 1);
              r.found = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.length = POS_W'(elems.size());
      owed_replies.push_back(r);
    endfunction

    task report_mismatch(string what, logic [63:0] want, logic [63:0] seen);
      errors++;
      $display("%0t ns: MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want, seen);
    endtask

    task check_reply(list_reply_t got);
      list_reply_t want;
      if (owed_replies.size() == 0) begin
        report_mismatch("unexpected transaction", 64'h0, 64'(got));
      end else begin
        want = owed_replies.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.data_value !== want.data_value)
          report_mismatch("data_value", 64'(want.data_value), 64'(got.data_value));
        if (got.last_value !== want.last_value)
          report_mismatch("last_value", 64'(want.last_value), 64'(got.last_value));
        if (got.found_position !== want.found_position)
          report_mismatch("found_position", 64'(want.found_position),
                          64'(got.found_position));
        if (got.found !== want.found)
          report_mismatch("found", 64'(want.found), 64'(got.found));
        if (got.length !== want.length)
          report_mismatch("length", 64'(want.length), 64'(got.length));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       in_opcode = '0;
  logic signed [DW-1:0]  in_value = '0;
  logic [POS_W-1:0]      in_position = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ST_W-1:0]       out_status;
  logic signed [DW-1:0]  out_data_value;
  logic signed [DW-1:0]  out_last_value;
  logic [POS_W-1:0]      out_found_position;
  logic                  out_found;
  logic [POS_W-1:0]      out_length;

  list_shadow shadow = new();
  int burst_left = 0;
  int replies_seen = 0;

  positional_list_engine_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_data_value     (out_data_value),
    .out_last_value     (out_last_value),
    .out_found_position (out_found_position),
    .out_found          (out_found),
    .out_length         (out_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offers one command and returns at the edge that accepts it.
  task automatic send_command(input logic [OP_W-1:0] op, input logic signed [DW-1:0] val,
                              input logic [POS_W-1:0] pos);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_value    <= val;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    shadow.apply_command(op, val, pos);
  endtask

  function automatic logic signed [DW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return DW'(int'($urandom_range(0, 6)) - 2);  // small pool, many duplicates
    if (r == 3) begin
      case ($urandom_range(0, 3))
        0: return MIN_WORD;
        1: return MAX_WORD;
        2: return '0;
        default: return '1;
      endcase
    end
    return DW'($urandom);
  endfunction

  function automatic logic [OP_W-1:0] pick_opcode(list_trend_t trend);
    logic [OP_W-1:0] grow_ops[3];
    logic [OP_W-1:0] shrink_ops[3];
    int unsigned r;
    grow_ops   = '{OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT};
    shrink_ops = '{OP_POP_FRONT, OP_POP_BACK, OP_DELETE};
    r = $urandom_range(0, 99);
    if (r < 3) return OP_W'($urandom_range(OP_SEARCH + 1, OP_LAST_CODE));
    if (r < 60 && trend == GROW) return grow_ops[$urandom_range(0, 2)];
    if (r < 60 && trend == SHRINK) return shrink_ops[$urandom_range(0, 2)];
    return OP_W'($urandom_range(OP_PUSH_FRONT, OP_SEARCH));
  endfunction

  function automatic logic [POS_W-1:0] pick_position(int len);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7 && len > 0) return POS_W'($urandom_range(1, len));
    if (r == 7) return '0;
    if (r == 8) return POS_W'(len + 1);
    return POS_W'($urandom_range(0, POS_TOP));
  endfunction

  // Receiver: checks accepted replies and stalls on its own pattern.
  initial begin
    list_reply_t got;
    int mode, mode_left, period, tick, hold_left;
    bit held_once;
    mode_left = 0;
    tick = 0;
    hold_left = 0;
    held_once = 1'b0;
    mode = 0;
    period = 4;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.status         = out_status;
        got.data_value     = out_data_value;
        got.last_value     = out_last_value;
        got.found_position = out_found_position;
        got.found          = out_found;
        got.length         = out_length;
        shadow.check_reply(got);
        replies_seen++;
      end
      if (!held_once && replies_seen >= HOLD_AFTER) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(64, 256);
          period = $urandom_range(3, 8);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          default: out_stall <= ((tick % period) < 2);
        endcase
      end
    end
  end

  initial begin
    logic [OP_W-1:0] op;
    logic signed [DW-1:0] val;
    logic [POS_W-1:0] pos;
    list_trend_t trend;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: every failing case first
    send_command(OP_POP_FRONT, '0, '0);
    send_command(OP_POP_BACK, '0, '0);
    send_command(OP_PEEK_ENDS, '0, '0);
    send_command(OP_READ, '0, '0);
    send_command(OP_DELETE, '0, 7'd1);
    send_command(OP_INSERT, '1, 7'd1);
    send_command(OP_WRITE, MAX_WORD, 7'd1);
    send_command(OP_SEARCH, '0, '0);
    // extremes of the data field
    send_command(OP_PUSH_BACK, MAX_WORD, '0);
    send_command(OP_PUSH_FRONT, MIN_WORD, '0);
    send_command(OP_PUSH_BACK, '0, '0);
    send_command(OP_PUSH_BACK, '1, '0);
    send_command(OP_PEEK_ENDS, '0, '0);
    send_command(OP_READ, '0, '0);
    send_command(OP_READ, '0, 7'd4);
    send_command(OP_READ, '0, 7'd5);
    send_command(OP_WRITE, 32'sh5555_5555, 7'd2);
    send_command(OP_INSERT, 32'shAAAA_AAAA, 7'd1);
    send_command(OP_INSERT, '1, 7'd5);
    send_command(OP_SEARCH, '1, '0);      // duplicate: the later position is reported
    send_command(OP_SEARCH, 32'sd12345, '0);
    send_command(OP_DELETE, '0, 7'd1);
    send_command(OP_LAST_CODE, '1, POS_TOP);
    send_command(OP_W'(OP_SEARCH + 1), '0, 7'd64);
    send_command(OP_POP_FRONT, '0, '0);
    send_command(OP_POP_BACK, '0, '0);

    for (int i = 0; i < RANDOM_COMMANDS; i++) begin
      case ((i / PHASE_LEN) % 3)
        0: trend = GROW;
        1: trend = MIXED;
        default: trend = SHRINK;
      endcase
      op = pick_opcode(trend);
      val = pick_value();
      if (op == OP_SEARCH && shadow.elems.size() > 0 && $urandom_range(0, 9) < 6)
        val = shadow.elems[$urandom_range(0, shadow.elems.size() - 1)];
      pos = pick_position(shadow.elems.size());
      send_command(op, val, pos);
    end
    in_valid <= 1'b0;

    while (shadow.owed_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.owed_replies.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_dpath.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine_unit.sv
tb/positional_list_engine_unit_test.sv
